// File: hw/rtl/spt3d_pkg.sv
// Package for the 3-D simple point test: octant tables and the closure step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spt3d_pkg;

   localparam int NB_COUNT  = 26;
   localparam int OCT_COUNT = 8;
   localparam int OCT_SIZE  = 7;

   typedef logic [NB_COUNT-1:0]  nb_bits_type;
   typedef logic [4:0]           nb_index_type;
   typedef logic [2:0]           oct_index_type;
   typedef logic [OCT_COUNT-1:0] oct_mask_type;
   typedef oct_mask_type [OCT_COUNT-1:0] oct_opens_type;

   // Octant that seeds the search for each neighbour index.
   localparam oct_index_type START_OCT [NB_COUNT] = '{
      3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd0, 3'd0, 3'd1, 3'd0,
      3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd7
   };

   // Neighbour indices held by each octant.
   localparam nb_index_type OCT_IDX [OCT_COUNT][OCT_SIZE] = '{
      '{5'd0,  5'd1,  5'd3,  5'd4,  5'd9,  5'd10, 5'd12},
      '{5'd1,  5'd4,  5'd10, 5'd2,  5'd5,  5'd11, 5'd13},
      '{5'd3,  5'd4,  5'd12, 5'd6,  5'd7,  5'd14, 5'd15},
      '{5'd4,  5'd5,  5'd13, 5'd7,  5'd15, 5'd8,  5'd16},
      '{5'd9,  5'd10, 5'd12, 5'd17, 5'd18, 5'd20, 5'd21},
      '{5'd10, 5'd11, 5'd13, 5'd18, 5'd21, 5'd19, 5'd22},
      '{5'd12, 5'd14, 5'd15, 5'd20, 5'd21, 5'd23, 5'd24},
      '{5'd13, 5'd15, 5'd16, 5'd21, 5'd22, 5'd24, 5'd25}
   };

   // Other octants that share each entry.
   localparam oct_mask_type OCT_OPENS [OCT_COUNT][OCT_SIZE] = '{
      '{8'h00, 8'h02, 8'h04, 8'h0E, 8'h10, 8'h32, 8'h54},
      '{8'h01, 8'h0D, 8'h31, 8'h00, 8'h08, 8'h20, 8'hA8},
      '{8'h01, 8'h0B, 8'h51, 8'h00, 8'h08, 8'h40, 8'hC8},
      '{8'h07, 8'h02, 8'hA2, 8'h04, 8'hC4, 8'h00, 8'h80},
      '{8'h01, 8'h23, 8'h45, 8'h00, 8'h20, 8'h40, 8'hE0},
      '{8'h13, 8'h02, 8'h8A, 8'h10, 8'hD0, 8'h00, 8'h80},
      '{8'h15, 8'h04, 8'h8C, 8'h10, 8'hB0, 8'h00, 8'h80},
      '{8'h2A, 8'h4C, 8'h08, 8'h70, 8'h20, 8'h40, 8'h00}
   };

   // One round of the octant closure.
   function automatic oct_mask_type close_step(oct_mask_type reached, oct_opens_type opens);
      oct_mask_type next;
      next = reached;
      for (int o = 0; o < OCT_COUNT; o++) begin
         if (reached[o]) begin
            next = next | opens[o];
         end
      end
      return next;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/simple_point_test_3d.sv
// Top level of the 3-D simple point test (octant connectivity, 26 neighbors).
// Depends on spt3d_pkg for the octant tables and the closure step.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request: drive req_neighbour_bits and pulse start; a request is taken at a
//   rising edge with start high and busy low. busy is low except during reset,
//   so one request can be taken in every cycle.
//   Response: rsp_strobe is high for one cycle with rsp_is_simple; responses
//   come out in request order. The receiver cannot hold them off, and the
//   block never needs it to.
//   Throughput: one request per cycle while busy is low.
//   Pipeline: stage 0 registers the input, finds the seed octant and the opens
//   mask of every octant; stages 1 to 4 each run two closure rounds over the
//   8 octants (8 rounds); the response register checks that every occupied
//   neighbor lies in a reached octant.
//   Reset: synchronous; clears the valid bits, so requests in flight are
//   dropped and no response strobes until new requests arrive.
//   An empty neighborhood reaches no octant and reports simple.
module simple_point_test_3d (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  spt3d_pkg::nb_bits_type req_neighbour_bits,
   output logic                  rsp_strobe,
   output logic                  rsp_is_simple
);
   import spt3d_pkg::*;

   localparam int CLOSE_STAGES = 4;
   localparam int STAGES       = CLOSE_STAGES + 1;
   localparam int ROUNDS_PER   = OCT_COUNT / CLOSE_STAGES;

   logic          valid_ff   [STAGES];
   nb_bits_type   bits_ff    [STAGES];
   oct_mask_type  reached_ff [STAGES];
   oct_opens_type opens_ff   [CLOSE_STAGES];

   logic          rsp_strobe_ff;
   logic          rsp_is_simple_ff;

   oct_mask_type  seed_in;
   oct_opens_type opens_in;
   oct_mask_type  reached_in [STAGES];
   logic          is_simple_in;
   nb_bits_type   covered;

   assign busy = reset;

   // stage 0 logic: seed octant from the lowest set bit, opens per octant
   always_comb begin
      seed_in  = '0;
      opens_in = '0;
      for (int k = NB_COUNT - 1; k >= 0; k--) begin
         if (req_neighbour_bits[k]) begin
            seed_in = oct_mask_type'(1) << START_OCT[k];
         end
      end
      for (int o = 0; o < OCT_COUNT; o++) begin
         for (int e = 0; e < OCT_SIZE; e++) begin
            if (req_neighbour_bits[OCT_IDX[o][e]]) begin
               opens_in[o] = opens_in[o] | OCT_OPENS[o][e];
            end
         end
      end
   end

   // closure stages
   always_comb begin
      reached_in[0] = seed_in;
      for (int s = 1; s < STAGES; s++) begin
         reached_in[s] = reached_ff[s-1];
         for (int r = 0; r < ROUNDS_PER; r++) begin
            reached_in[s] = close_step(reached_in[s], opens_ff[s-1]);
         end
      end
   end

   // final coverage check
   always_comb begin
      covered = '0;
      for (int o = 0; o < OCT_COUNT; o++) begin
         if (reached_ff[STAGES-1][o]) begin
            for (int e = 0; e < OCT_SIZE; e++) begin
               covered[OCT_IDX[o][e]] = 1'b1;
            end
         end
      end
      is_simple_in = ((bits_ff[STAGES-1] & ~covered) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff[0] <= start && !busy;
         for (int s = 1; s < STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         rsp_strobe_ff <= valid_ff[STAGES-1];
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      bits_ff[0]    <= req_neighbour_bits;
      reached_ff[0] <= reached_in[0];
      opens_ff[0]   <= opens_in;
      for (int s = 1; s < STAGES; s++) begin
         bits_ff[s]    <= bits_ff[s-1];
         reached_ff[s] <= reached_in[s];
      end
      for (int s = 1; s < CLOSE_STAGES; s++) begin
         opens_ff[s]   <= opens_ff[s-1];
      end
      rsp_is_simple_ff <= is_simple_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_is_simple = rsp_is_simple_ff;

   // every request yields a response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_strobe)
      else $error("response missing after request");

   // empty neighborhood is simple
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_neighbour_bits == '0) |-> ##6 (rsp_strobe && rsp_is_simple))
      else $error("empty neighborhood not reported simple");

   // one occupied neighbor is simple
   a_single: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && $onehot(req_neighbour_bits)) |-> ##6 rsp_is_simple)
      else $error("single neighbor not reported simple");

   // closure only grows the reached set
   a_grow: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> ((reached_ff[2] & $past(reached_ff[1])) == $past(reached_ff[1])))
      else $error("reached octants shrank");

endmodule

`default_nettype wire

// File: tb/sv/simple_point_test_3d_tb.sv
// Testbench for simple_point_test_3d: a directed table, then about 400 random
// neighborhoods, checked against its own octant-closure model where no result is typed in.
// Depends on spt3d_pkg for the port types and on the simple_point_test_3d RTL.
`timescale 1ns / 1ps

module simple_point_test_3d_tb;

   import spt3d_pkg::*;

   localparam int CYCLE_LIMIT  = 50000;
   localparam int DRAIN_CYCLES = 12;
   localparam int NUM_DIRECTED = 17;
   localparam int RANDOM_PHASE = 100;    // requests per random phase

   // Neighbor indices held by each octant (2x2x2 corner blocks around the
   // center). Bit k of entry o is set when octant o holds neighbor k.
   // Two octants sharing a neighbor are linked through it, which is
   // exactly what the per-entry opens masks of the octant tables encode.
   localparam logic [7:0][25:0] OCTANT_MEMBERS = {
      26'h361A000,   // octant 7
      26'h1B0D000,   // octant 6
      26'h06C2C00,   // octant 5
      26'h0361600,   // octant 4
      26'h001A1B0,   // octant 3
      26'h000D0D8,   // octant 2
      26'h0002C36,   // octant 1
      26'h000161B    // octant 0
   };

   typedef struct packed {
      nb_bits_type bits;
      logic        is_simple;
   } awaited_result_type;

   typedef struct {
      nb_bits_type bits;
      bit          given;       // is_simple below is typed in, not predicted
      bit          is_simple;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   nb_bits_type req_neighbour_bits = '0;
   wire         busy;
   wire         rsp_strobe;
   wire         rsp_is_simple;

   awaited_result_type awaited_is_simple[$];
   int unsigned        mismatch_count = 0;
   int unsigned        cycle_count = 0;

   // Corner cases first: empty, full, lone voxels, opposite corners and faces,
   // checkerboards, whole octants and near-full neighborhoods.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{26'h0000000, 1'b1, 1'b1},   // empty neighborhood is simple
      '{26'h3FFFFFF, 1'b1, 1'b1},   // fully occupied: one group
      '{26'h0000001, 1'b1, 1'b1},   // lone lowest corner
      '{26'h2000000, 1'b1, 1'b1},   // lone highest corner
      '{26'h0000100, 1'b1, 1'b1},   // lone corner seeding octant 3
      '{26'h2000001, 1'b1, 1'b0},   // opposite corners, nothing between
      '{26'h0000044, 1'b0, 1'b0},   // two corners in different octants
      '{26'h0200010, 1'b0, 1'b0},   // opposite face centers
      '{26'h020B410, 1'b0, 1'b0},   // all six face centers
      '{26'h2AAAAAA, 1'b0, 1'b0},
      '{26'h1555555, 1'b0, 1'b0},
      '{26'h361A000, 1'b0, 1'b0},   // whole top octant
      '{26'h3FFFFFE, 1'b0, 1'b0},
      '{26'h1FFFFFF, 1'b0, 1'b0},
      '{26'h0000003, 1'b0, 1'b0},
      '{26'h0000005, 1'b0, 1'b0},
      '{26'h0820000, 1'b0, 1'b0}
   };

   simple_point_test_3d dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_neighbour_bits (req_neighbour_bits),
      .rsp_strobe         (rsp_strobe),
      .rsp_is_simple      (rsp_is_simple)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Connectivity over octants: seed with the lowest octant holding the
   // lowest occupied neighbor, then keep reaching every octant that holds an
   // occupied neighbor of an already reached octant. Nine rounds cover the
   // seven growth steps with margin. Simple when nothing occupied is left out.
   function automatic logic is_simple_point(nb_bits_type occupied);
      oct_mask_type reached;
      oct_mask_type grown;
      nb_bits_type  covered;
      int           first;
      if (occupied == '0) begin
         return 1'b1;
      end
      first = 0;
      while (!occupied[first]) begin
         first++;
      end
      reached = '0;
      for (int o = 0; o < 8; o++) begin
         if (reached == '0 && OCTANT_MEMBERS[o][first]) begin
            reached[o] = 1'b1;
         end
      end
      covered = '0;
      for (int round = 0; round < 9; round++) begin
         covered = '0;
         for (int o = 0; o < 8; o++) begin
            if (reached[o]) begin
               covered = covered | OCTANT_MEMBERS[o];
            end
         end
         grown = reached;
         for (int o = 0; o < 8; o++) begin
            if ((OCTANT_MEMBERS[o] & occupied & covered) != '0) begin
               grown[o] = 1'b1;
            end
         end
         reached = grown;
      end
      return ((occupied & ~covered) == '0);
   endfunction

   // Mix of shapes: uniform noise, a few scattered voxels, filled parts of one
   // or two octants (mostly one group), and dense fills.
   function automatic nb_bits_type random_neighbourhood();
      nb_bits_type bits;
      nb_bits_type pair;
      int          count;
      bits = '0;
      case ($urandom_range(4))
         0: begin
            bits = nb_bits_type'($urandom());
         end
         1: begin
            count = $urandom_range(1, 3);
            repeat (count) bits[$urandom_range(25)] = 1'b1;
         end
         2: begin
            bits = OCTANT_MEMBERS[$urandom_range(7)] & nb_bits_type'($urandom());
         end
         3: begin
            pair = OCTANT_MEMBERS[$urandom_range(7)] | OCTANT_MEMBERS[$urandom_range(7)];
            bits = pair & nb_bits_type'($urandom() | $urandom());
         end
         default: begin
            bits = nb_bits_type'($urandom() | $urandom());
         end
      endcase
      return bits;
   endfunction

   // Drive one request, with random idle cycles in front of it. start stays
   // high from one request to the next when no idle cycle falls between.
   task automatic send_request(input nb_bits_type bits, input logic is_simple,
                               input int idle_pct);
      awaited_result_type entry;
      while ($urandom_range(99) < idle_pct) begin
         start              <= 1'b0;
         req_neighbour_bits <= nb_bits_type'($urandom());   // junk while idle
         @(posedge clock);
      end
      start              <= 1'b1;
      req_neighbour_bits <= bits;
      // busy as sampled here is the value of the cycle that just ended
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      entry.bits      = bits;
      entry.is_simple = is_simple;
      awaited_is_simple.push_back(entry);
   endtask

   // Response checker: each strobe takes the oldest outstanding request.
   always @(posedge clock) begin
      awaited_result_type head;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_is_simple.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual is_simple %0b",
                     $time, rsp_is_simple);
            mismatch_count++;
         end else begin
            head = awaited_is_simple.pop_front();
            if (rsp_is_simple !== head.is_simple) begin
               $display("%0t: is_simple for %h: expected %0b, actual %0b",
                        $time, head.bits, head.is_simple, rsp_is_simple);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL simple_point_test_3d");
      $finish;
   end

   initial begin
      int          idle_pct;
      nb_bits_type bits;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table, back to back
      for (int row = 0; row < NUM_DIRECTED; row++) begin
         if (directed_rows[row].given) begin
            send_request(directed_rows[row].bits, directed_rows[row].is_simple, 0);
         end else begin
            send_request(directed_rows[row].bits,
                         is_simple_point(directed_rows[row].bits), 0);
         end
      end

      // Random phases: no gaps, sparse sender, back to back again (the
      // receiver cannot stall), then moderate gaps.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       idle_pct = 67;
            3:       idle_pct = 36;
            default: idle_pct = 0;
         endcase
         repeat (RANDOM_PHASE) begin
            bits = random_neighbourhood();
            send_request(bits, is_simple_point(bits), idle_pct);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (awaited_is_simple.size() != 0) begin
         @(posedge clock);
      end
      // let any stray strobe show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS simple_point_test_3d");
      end else begin
         $display("FAIL simple_point_test_3d");
      end
      $finish;
   end

endmodule
